FILE: rtl/core/imab_pkg.sv
// ============================================================================
// imab_pkg - shared types and tables of the IMA ADPCM block decoder
// Step size table, index adjust table, register indexes and decoder state.
// ============================================================================
package imab_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_OFFSET = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_SKIP   = 2'd2;

  localparam int STEP_W  = 15;
  localparam int INDEX_W = 7;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;

  localparam logic [STEP_W-1:0] STEP_TABLE [89] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  // predictor and step index that one code moves forward
  typedef struct packed {
    logic signed [15:0]  predictor;
    logic [INDEX_W-1:0]  step_index;
  } imab_dec_state_t;

  function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
    logic [INDEX_W-1:0] clamped;
    clamped = (idx > INDEX_MAX) ? INDEX_MAX : idx;
    return STEP_TABLE[clamped];
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    unique case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

FILE: rtl/core/imab_if.sv
// ============================================================================
// imab_if - stream channels of the IMA ADPCM block decoder
// Byte channel into the decoder and sample channel out of it.
// ============================================================================
interface imab_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface imab_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [31:0]        dest_index;
  logic               last;

  modport source (output valid, output sample, output dest_index, output last, input ready);
  modport sink   (input valid, input sample, input dest_index, input last, output ready);
endinterface

FILE: rtl/core/imab_nib_dec.sv
// ============================================================================
// imab_nib_dec - one IMA ADPCM code step
// Adds or subtracts the scaled step, saturates, and moves the step index.
// ============================================================================
module imab_nib_dec (
  input  imab_pkg::imab_dec_state_t cur,
  input  logic [3:0]                code,
  output imab_pkg::imab_dec_state_t nxt
);
  import imab_pkg::*;

  logic [STEP_W-1:0]  step;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [8:0]  idx_sum;

  always_comb begin
    step = step_lookup(cur.step_index);
    diff = 17'(step >> 3);
    if (code[0]) diff = diff + 17'(step >> 2);
    if (code[1]) diff = diff + 17'(step >> 1);
    if (code[2]) diff = diff + 17'(step);
    if (code[3]) sum = 18'(cur.predictor) - signed'({1'b0, diff});
    else         sum = 18'(cur.predictor) + signed'({1'b0, diff});
    // saturate to signed 16 bits
    if (sum > 18'sd32767)       nxt.predictor = 16'sh7FFF;
    else if (sum < -18'sd32768) nxt.predictor = 16'sh8000;
    else                        nxt.predictor = sum[15:0];

    idx_sum = signed'({2'b00, cur.step_index}) + 9'(index_adjust(code[2:0]));
    if (idx_sum < 9'sd0)                         nxt.step_index = '0;
    else if (idx_sum > signed'({2'b00, INDEX_MAX})) nxt.step_index = INDEX_MAX;
    else                                         nxt.step_index = idx_sum[INDEX_W-1:0];
  end

endmodule

FILE: rtl/core/ima_adpcm_block_decoder.sv
// ============================================================================
// ima_adpcm_block_decoder - IMA ADPCM container decoder, one byte per item
// Parses the container and block headers and decodes 4-bit codes to PCM.
// ============================================================================
// A byte accepted on the stream channel lands in a work register. Header
// bytes are absorbed and give no sample; the pad byte of a block header
// gives the initial sample; a code byte gives its low-nibble sample first
// and, unless the block ends there, its high-nibble sample after it. One
// IMA step unit is shared by both nibbles, so a code byte stays in the
// work register until both its samples are out. While code bytes flow and
// the pcm sink is ready, the pcm channel carries one sample a cycle. Every
// sample passes through one output register; the work register keeps
// moving while the pcm sink is ready or the output register is empty. The
// input ready follows the output ready combinationally. Configuration is
// written through cfg_wr_en/cfg_index/cfg_data while the block is idle; a
// write of out_offset before the first stream byte also sets the first
// destination. Bytes after the last block are accepted and dropped.
// ============================================================================
module ima_adpcm_block_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [imab_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  imab_byte_if.sink                     stream,
  imab_sample_if.source                 pcm
);
  import imab_pkg::*;

  // configuration
  logic byte_order, out_skip;

  // container and block bookkeeping
  logic [3:0]         header_count,       header_count_next;
  logic [31:0]        assembly_shift,     assembly_shift_next;
  logic [15:0]        block_size_samples, block_size_samples_next;
  logic [31:0]        block_total,        block_total_next;
  logic [31:0]        blocks_done,        blocks_done_next;
  logic [15:0]        sample_in_block,    sample_in_block_next;
  logic [1:0]         block_header_count, block_header_count_next;
  logic signed [15:0] predictor,          predictor_next;
  logic [INDEX_W-1:0] step_index,         step_index_next;
  logic [3:0]         pending_nibble,     pending_nibble_next;
  logic [31:0]        dest_counter,       dest_counter_next;
  logic               stream_done,        stream_done_next;

  // work register: the byte being worked on and which nibble is due
  logic       work_valid;
  logic [7:0] work_byte;
  logic       work_phase, work_phase_next;

  // output register
  logic               out_valid;
  logic signed [15:0] out_sample;
  logic [31:0]        out_dest;
  logic               out_last;

  logic               out_free, fire, done, emit, accept;
  logic signed [15:0] emit_sample;
  logic               emit_last;
  logic [31:0]        shift_taken;
  logic [16:0]        sib_inc;
  logic               block_end, final_sample;
  imab_dec_state_t    dec_cur, dec_nxt;
  logic [3:0]         dec_code;

  function automatic logic [15:0] assembled16(input logic order, input logic [31:0] x);
    return order ? x[15:0] : x[31:16];
  endfunction

  assign out_free = !out_valid || pcm.ready;
  assign fire     = work_valid && out_free;
  assign accept   = stream.valid && stream.ready;
  assign stream.ready = !work_valid || done;

  // shared code step: low nibble first, then the held high nibble
  assign dec_cur.predictor  = predictor;
  assign dec_cur.step_index = step_index;
  assign dec_code = work_phase ? pending_nibble : work_byte[3:0];

  imab_nib_dec u_nib_dec (
    .cur  (dec_cur),
    .code (dec_code),
    .nxt  (dec_nxt)
  );

  // next byte shifted into the field assembly register
  assign shift_taken = byte_order ? {assembly_shift[23:0], work_byte}
                                  : {work_byte, assembly_shift[31:8]};

  // end of block and end of stream for a sample emitted now
  assign sib_inc      = {1'b0, sample_in_block} + 17'd1;
  assign block_end    = sib_inc >= {1'b0, block_size_samples};
  assign final_sample = block_end && (blocks_done + 32'd1 == block_total);

  always_comb begin
    header_count_next       = header_count;
    assembly_shift_next     = assembly_shift;
    block_size_samples_next = block_size_samples;
    block_total_next        = block_total;
    blocks_done_next        = blocks_done;
    sample_in_block_next    = sample_in_block;
    block_header_count_next = block_header_count;
    predictor_next          = predictor;
    step_index_next         = step_index;
    pending_nibble_next     = pending_nibble;
    dest_counter_next       = dest_counter;
    stream_done_next        = stream_done;
    work_phase_next         = work_phase;
    done                    = 1'b0;
    emit                    = 1'b0;
    emit_sample             = dec_nxt.predictor;
    emit_last               = final_sample;

    if (fire) begin
      if (work_phase) begin
        // high nibble of a code byte
        predictor_next  = dec_nxt.predictor;
        step_index_next = dec_nxt.step_index;
        emit = 1'b1;
        done = 1'b1;
      end else if (stream_done) begin
        // trailing bytes are dropped
        done = 1'b1;
      end else if (header_count < 4'd8) begin
        // container header
        assembly_shift_next = shift_taken;
        header_count_next   = header_count + 4'd1;
        if (header_count == 4'd3)
          block_size_samples_next = assembled16(byte_order, shift_taken);
        if (header_count == 4'd7) begin
          block_total_next = shift_taken;
          if (block_size_samples == 16'd0 || shift_taken == 32'd0)
            stream_done_next = 1'b1;
        end
        done = 1'b1;
      end else if (sample_in_block == 16'd0) begin
        // block header
        done = 1'b1;
        if (block_header_count < 2'd2) begin
          assembly_shift_next     = shift_taken;
          block_header_count_next = block_header_count + 2'd1;
        end else if (block_header_count == 2'd2) begin
          step_index_next = (work_byte > 8'(INDEX_MAX)) ? INDEX_MAX
                                                        : work_byte[INDEX_W-1:0];
          block_header_count_next = 2'd3;
        end else begin
          // pad byte: the initial sample goes out
          predictor_next          = signed'(assembled16(byte_order, assembly_shift));
          emit_sample             = signed'(assembled16(byte_order, assembly_shift));
          block_header_count_next = 2'd0;
          emit = 1'b1;
        end
      end else begin
        // low nibble of a code byte
        predictor_next      = dec_nxt.predictor;
        step_index_next     = dec_nxt.step_index;
        pending_nibble_next = work_byte[7:4];
        emit = 1'b1;
        if (block_end) done = 1'b1;
        else           work_phase_next = 1'b1;
      end
    end

    if (done) work_phase_next = 1'b0;

    // per-sample bookkeeping
    if (emit) begin
      dest_counter_next = dest_counter + (out_skip ? 32'd2 : 32'd1);
      if (block_end) begin
        sample_in_block_next    = '0;
        block_header_count_next = '0;
        blocks_done_next        = blocks_done + 32'd1;
        if (final_sample) stream_done_next = 1'b1;
      end else begin
        sample_in_block_next = sib_inc[15:0];
      end
    end

    // out_offset written before the first stream byte sets the first slot
    if (cfg_wr_en && cfg_index == REG_OUT_OFFSET && header_count == 4'd0)
      dest_counter_next = {31'd0, cfg_data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order         <= 1'b0;
      out_skip           <= 1'b0;
      header_count       <= '0;
      assembly_shift     <= '0;
      block_size_samples <= '0;
      block_total        <= '0;
      blocks_done        <= '0;
      sample_in_block    <= '0;
      block_header_count <= '0;
      predictor          <= '0;
      step_index         <= '0;
      pending_nibble     <= '0;
      dest_counter       <= '0;
      stream_done        <= 1'b0;
      work_valid         <= 1'b0;
      work_phase         <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      header_count       <= header_count_next;
      assembly_shift     <= assembly_shift_next;
      block_size_samples <= block_size_samples_next;
      block_total        <= block_total_next;
      blocks_done        <= blocks_done_next;
      sample_in_block    <= sample_in_block_next;
      block_header_count <= block_header_count_next;
      predictor          <= predictor_next;
      step_index         <= step_index_next;
      pending_nibble     <= pending_nibble_next;
      dest_counter       <= dest_counter_next;
      stream_done        <= stream_done_next;
      work_phase         <= work_phase_next;

      // configuration writes must arrive only while idle (the block does not
      // enforce it); out_offset only acts on the first destination slot above
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BYTE_ORDER: byte_order <= cfg_data;
          REG_OUT_SKIP:   out_skip <= cfg_data;
          default: ;
        endcase
      end

      if (accept)    work_valid <= 1'b1;
      else if (done) work_valid <= 1'b0;

      if (emit)           out_valid <= 1'b1;
      else if (pcm.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) work_byte <= stream.stream_byte;
    if (emit) begin
      out_sample <= emit_sample;
      out_dest   <= dest_counter;
      out_last   <= emit_last;
    end
  end

  assign pcm.valid      = out_valid;
  assign pcm.sample     = out_sample;
  assign pcm.dest_index = out_dest;
  assign pcm.last       = out_last;

endmodule
